// ===== rtl/pfc_pkg.sv =====
package pfc_pkg;

  // Square geometry and field widths
  localparam int SQUARE_SIDE = 5;
  localparam int NUM_ROWS    = 5;
  localparam int NUM_COLS    = 5;
  localparam int LW          = 5;
  localparam int ROW_W       = NUM_COLS * LW;
  localparam int POS_W       = $clog2(SQUARE_SIDE);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = ROW_W;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = $clog2(QDEPTH);
  localparam int QCNT_W      = $clog2(QDEPTH + 1);

  typedef logic [LW-1:0]    letter_t;
  typedef logic [POS_W-1:0] idx_t;

  localparam letter_t LETTER_I     = letter_t'(8);
  localparam letter_t LETTER_J     = letter_t'(9);
  localparam letter_t FILLER_RESET = letter_t'(23);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 3'd0,
    REG_ROW0   = 3'd1,
    REG_ROW1   = 3'd2,
    REG_ROW2   = 3'd3,
    REG_ROW3   = 3'd4,
    REG_ROW4   = 3'd5,
    REG_FILLER = 3'd6
  } cfg_reg_t;

  typedef logic [NUM_ROWS-1:0][ROW_W-1:0] rows_t;

  typedef struct packed {
    logic    decrypt_mode;
    letter_t filler;
    rows_t   rows;
  } cfg_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    JK_ENC,
    JK_DEC,
    JK_MARK
  } job_kind_t;

  typedef struct packed {
    job_kind_t kind;
    letter_t   a;
    letter_t   b;
    logic      last;
    logic      err;
  } job_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  typedef struct packed {
    letter_t letter;
    logic    lv;
    logic    eom;
    logic    err;
  } res_t;

  // Treat j as i
  function automatic letter_t fold_j(letter_t v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  // Cells beyond the loaded square read as letter 0
  function automatic letter_t cell_at(rows_t rows, idx_t r, idx_t c);
    letter_t res;
    res = '0;
    if (int'(r) < NUM_ROWS && int'(c) < NUM_COLS) begin
      res = rows[r][int'(c)*LW +: LW];
    end
    return res;
  endfunction

  // First match in row-major order, row 0 column 0 when absent
  function automatic pos_t locate(rows_t rows, letter_t v);
    pos_t p;
    logic found;
    p     = '0;
    found = 1'b0;
    for (int r = 0; r < SQUARE_SIDE; r++) begin
      for (int c = 0; c < SQUARE_SIDE; c++) begin
        if (!found && cell_at(rows, idx_t'(r), idx_t'(c)) == v) begin
          p.row = idx_t'(r);
          p.col = idx_t'(c);
          found = 1'b1;
        end
      end
    end
    return p;
  endfunction

  // Move one place round the square: forward to encipher, back to decipher
  function automatic idx_t step_idx(idx_t i, logic back);
    idx_t res;
    if (back) begin
      res = (i == '0) ? idx_t'(SQUARE_SIDE - 1) : idx_t'(i - 1'b1);
    end else begin
      res = (i == idx_t'(SQUARE_SIDE - 1)) ? '0 : idx_t'(i + 1'b1);
    end
    return res;
  endfunction

endpackage

// ===== rtl/pfc_in_if.sv =====
interface pfc_in_if import pfc_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t letter;
  logic    final_letter;

  modport source (output valid, letter, final_letter, input ready);
  modport sink   (input valid, letter, final_letter, output ready);
endinterface

// ===== rtl/pfc_out_if.sv =====
interface pfc_out_if import pfc_pkg::*; ();
  logic    valid;
  logic    ready;
  letter_t out_letter;
  logic    letter_valid;
  logic    end_of_message;
  logic    odd_error;

  modport source (output valid, out_letter, letter_valid, end_of_message, odd_error,
                  input ready);
  modport sink   (input valid, out_letter, letter_valid, end_of_message, odd_error,
                  output ready);
endinterface

// ===== rtl/pfc_queue.sv =====
module pfc_queue import pfc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_data,
  output logic  full,
  input  logic  pop,
  output job_t  pop_data,
  output logic  empty
);

  job_t                ent_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push;
  logic                do_pop;

  assign full     = (cnt_r == QCNT_W'(QDEPTH));
  assign empty    = (cnt_r == '0);
  assign pop_data = ent_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Store entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= QPTR_W'(wr_ptr_r + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_r <= QPTR_W'(rd_ptr_r + 1'b1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= QCNT_W'(cnt_r + 1'b1);
      end else if (do_pop && !do_push) begin
        cnt_r <= QCNT_W'(cnt_r - 1'b1);
      end
    end
  end

endmodule

// ===== rtl/pfc_front.sv =====
module pfc_front import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  pfc_in_if.sink     in_ch,
  output logic       q_push,
  output job_t       q_data,
  input  logic       q_full
);

  logic    pend_v_r;
  letter_t pend_r;
  logic    extra_v_r;
  job_t    extra_r;

  logic    accept;
  letter_t l;
  letter_t fill;
  logic    fin;
  logic    push_now;
  job_t    job_now;
  logic    need_extra;
  job_t    extra_job;
  logic    pend_v_nxt;
  letter_t pend_nxt;

  assign in_ch.ready = !extra_v_r && !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign l           = fold_j(in_ch.letter);
  assign fin         = in_ch.final_letter;
  assign fill        = fold_j(cfg.filler);

  // Classify the word against the pending letter
  always_comb begin
    push_now        = 1'b0;
    job_now         = '0;
    need_extra      = 1'b0;
    extra_job       = '0;
    pend_v_nxt      = pend_v_r;
    pend_nxt        = pend_r;
    if (!cfg.decrypt_mode) begin
      if (!pend_v_r) begin
        if (fin) begin
          push_now      = 1'b1;
          job_now.kind  = JK_ENC;
          job_now.a     = l;
          job_now.b     = fill;
          job_now.last  = 1'b1;
        end else begin
          pend_v_nxt = 1'b1;
          pend_nxt   = l;
        end
      end else if (pend_r == l) begin
        push_now      = 1'b1;
        job_now.kind  = JK_ENC;
        job_now.a     = pend_r;
        job_now.b     = fill;
        job_now.last  = 1'b0;
        if (fin) begin
          need_extra     = 1'b1;
          extra_job.kind = JK_ENC;
          extra_job.a    = l;
          extra_job.b    = fill;
          extra_job.last = 1'b1;
          pend_v_nxt     = 1'b0;
        end
      end else begin
        push_now      = 1'b1;
        job_now.kind  = JK_ENC;
        job_now.a     = pend_r;
        job_now.b     = l;
        job_now.last  = fin;
        pend_v_nxt    = 1'b0;
      end
    end else begin
      if (!pend_v_r) begin
        if (fin) begin
          push_now      = 1'b1;
          job_now.kind  = JK_MARK;
          job_now.last  = 1'b1;
          job_now.err   = 1'b1;
        end else begin
          pend_v_nxt = 1'b1;
          pend_nxt   = l;
        end
      end else begin
        push_now      = 1'b1;
        job_now.kind  = JK_DEC;
        job_now.a     = pend_r;
        job_now.b     = l;
        job_now.last  = fin;
        pend_v_nxt    = 1'b0;
      end
    end
    // A final letter always ends the message
    if (fin) begin
      pend_v_nxt = 1'b0;
    end
  end

  // Feed the queue: a held second pair goes first
  always_comb begin
    if (extra_v_r) begin
      q_push = !q_full;
      q_data = extra_r;
    end else begin
      q_push = accept && push_now;
      q_data = job_now;
    end
  end

  // Hold pending letter and second pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r  <= 1'b0;
      pend_r    <= '0;
      extra_v_r <= 1'b0;
    end else begin
      if (accept) begin
        pend_v_r <= pend_v_nxt;
        pend_r   <= pend_nxt;
      end
      if (accept && need_extra) begin
        extra_v_r <= 1'b1;
      end else if (extra_v_r && !q_full) begin
        extra_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && need_extra) begin
      extra_r <= extra_job;
    end
  end

endmodule

// ===== rtl/pfc_back.sv =====
module pfc_back import pfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       q_empty,
  input  job_t       q_data,
  output logic       q_pop,
  pfc_out_if.source  out_ch
);

  // Locate stage
  logic    loc_v_r;
  job_t    loc_job_r;
  pos_t    loc_p1_r;
  pos_t    loc_p2_r;
  // Result buffer, slot 0 leaves first
  logic [1:0] em_v_r;
  res_t    em0_r;
  res_t    em1_r;
  // Output register
  logic    out_v_r;
  res_t    out_r;

  logic    out_load;
  logic    em_free;
  logic    em_load;
  logic    back;
  letter_t fill;
  letter_t x;
  letter_t y;
  logic    keep_x;
  logic    keep_y;
  logic [1:0] em_v_nxt;
  res_t    em0_nxt;
  res_t    em1_nxt;

  assign out_load = em_v_r[0] && (!out_v_r || out_ch.ready);
  assign em_free  = (em_v_r == 2'b00) || (em_v_r == 2'b01 && out_load);
  assign em_load  = loc_v_r && em_free;
  assign q_pop    = !q_empty && (!loc_v_r || em_load);
  assign fill     = fold_j(cfg.filler);
  assign back     = (loc_job_r.kind == JK_DEC);

  // Apply the row, column or rectangle rule
  always_comb begin
    if (loc_p1_r.row == loc_p2_r.row) begin
      x = cell_at(cfg.rows, loc_p1_r.row, step_idx(loc_p1_r.col, back));
      y = cell_at(cfg.rows, loc_p2_r.row, step_idx(loc_p2_r.col, back));
    end else if (loc_p1_r.col == loc_p2_r.col) begin
      x = cell_at(cfg.rows, step_idx(loc_p1_r.row, back), loc_p1_r.col);
      y = cell_at(cfg.rows, step_idx(loc_p2_r.row, back), loc_p2_r.col);
    end else begin
      x = cell_at(cfg.rows, loc_p1_r.row, loc_p2_r.col);
      y = cell_at(cfg.rows, loc_p2_r.row, loc_p1_r.col);
    end
  end

  assign keep_x = (x != fill);
  assign keep_y = (y != fill);

  // Pack the job's results into the buffer slots
  always_comb begin
    em_v_nxt = 2'b00;
    em0_nxt  = '0;
    em1_nxt  = '0;
    unique case (loc_job_r.kind)
      JK_ENC: begin
        em_v_nxt       = 2'b11;
        em0_nxt.letter = x;
        em0_nxt.lv     = 1'b1;
        em1_nxt.letter = y;
        em1_nxt.lv     = 1'b1;
      end
      JK_DEC: begin
        unique case ({keep_x, keep_y})
          2'b11: begin
            em_v_nxt       = 2'b11;
            em0_nxt.letter = x;
            em0_nxt.lv     = 1'b1;
            em1_nxt.letter = y;
            em1_nxt.lv     = 1'b1;
          end
          2'b10: begin
            em_v_nxt       = 2'b01;
            em0_nxt.letter = x;
            em0_nxt.lv     = 1'b1;
          end
          2'b01: begin
            em_v_nxt       = 2'b01;
            em0_nxt.letter = y;
            em0_nxt.lv     = 1'b1;
          end
          default: begin
            em_v_nxt = loc_job_r.last ? 2'b01 : 2'b00;
          end
        endcase
      end
      JK_MARK: begin
        em_v_nxt    = 2'b01;
        em0_nxt.err = loc_job_r.err;
      end
      default: begin
        em_v_nxt = 2'b00;
      end
    endcase
    // Mark the message end on the last result
    if (loc_job_r.last) begin
      if (em_v_nxt[1]) begin
        em1_nxt.eom = 1'b1;
      end else begin
        em0_nxt.eom = 1'b1;
      end
    end
  end

  // Advance pipeline valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loc_v_r <= 1'b0;
      em_v_r  <= 2'b00;
      out_v_r <= 1'b0;
    end else begin
      if (q_pop) begin
        loc_v_r <= 1'b1;
      end else if (em_load) begin
        loc_v_r <= 1'b0;
      end
      if (em_load) begin
        em_v_r <= em_v_nxt;
      end else if (out_load) begin
        em_v_r <= {1'b0, em_v_r[1]};
      end
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Move payloads
  always_ff @(posedge clk) begin
    if (q_pop) begin
      loc_job_r <= q_data;
      loc_p1_r  <= locate(cfg.rows, q_data.a);
      loc_p2_r  <= locate(cfg.rows, q_data.b);
    end
    if (em_load) begin
      em0_r <= em0_nxt;
      em1_r <= em1_nxt;
    end else if (out_load) begin
      em0_r <= em1_r;
    end
    if (out_load) begin
      out_r <= em0_r;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_letter     = out_r.letter;
  assign out_ch.letter_valid   = out_r.lv;
  assign out_ch.end_of_message = out_r.eom;
  assign out_ch.odd_error      = out_r.err;

endmodule

// ===== rtl/playfair_digraph_cipher_top.sv =====
// Each completed pair passes through the job queue, locate stage, result buffer and
// output register to out_ch. Input takes one word per cycle unless the queue is full
// or a second pair is held; results leave the output register at one word per cycle
// while out_ch.ready is high, and a doubled final letter holds the input while its second pair is queued.
// Reset (rst_n low, synchronous): clears pending letter, job queue and pipeline;
// sets encrypt mode, all square rows to 0 and the filler to x.
module playfair_digraph_cipher_top import pfc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  pfc_in_if.sink                 in_ch,
  pfc_out_if.source              out_ch
);

  cfg_t cfg_r;
  logic q_push;
  job_t q_push_data;
  logic q_full;
  logic q_pop;
  job_t q_pop_data;
  logic q_empty;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.decrypt_mode <= 1'b0;
      cfg_r.filler       <= FILLER_RESET;
      cfg_r.rows         <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MODE:   cfg_r.decrypt_mode <= cfg_data[0];
        REG_ROW0:   cfg_r.rows[0]      <= cfg_data;
        REG_ROW1:   cfg_r.rows[1]      <= cfg_data;
        REG_ROW2:   cfg_r.rows[2]      <= cfg_data;
        REG_ROW3:   cfg_r.rows[3]      <= cfg_data;
        REG_ROW4:   cfg_r.rows[4]      <= cfg_data;
        REG_FILLER: cfg_r.filler       <= cfg_data[LW-1:0];
        default: begin
        end
      endcase
    end
  end

  pfc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_push (q_push),
    .q_data (q_push_data),
    .q_full (q_full)
  );

  pfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .empty     (q_empty)
  );

  pfc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .q_empty (q_empty),
    .q_data  (q_pop_data),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ===== tb/pfc_word_checker.sv =====
module pfc_word_checker import pfc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pfc_in_if                     in_ch,
  pfc_out_if                    out_ch,
  output int                    fail_count,
  output int                    words_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    letter_t letter;
    logic    lv;
    logic    eom;
    logic    err;
  } cipher_word_t;

  // Shadow of the block's registers and letter state
  logic    decipher;
  rows_t   square;
  letter_t filler;
  letter_t held_letter;
  logic    held_valid;

  cipher_word_t due_words[$];

  function automatic letter_t as_i(letter_t v);
    return (v == LETTER_J) ? LETTER_I : v;
  endfunction

  function automatic letter_t square_cell(int r, int c);
    if (r >= NUM_ROWS || c >= NUM_COLS) return '0;
    return square[r][c*LW +: LW];
  endfunction

  // Scan backwards so the last hit is the first cell in row-major order
  function automatic void find_cell(letter_t v, output int row, output int col);
    row = 0;
    col = 0;
    for (int r = SQUARE_SIDE - 1; r >= 0; r--) begin
      for (int c = SQUARE_SIDE - 1; c >= 0; c--) begin
        if (square_cell(r, c) == v) begin
          row = r;
          col = c;
        end
      end
    end
  endfunction

  // Shift of 1 enciphers, shift of SQUARE_SIDE-1 deciphers
  function automatic void map_pair(letter_t a, letter_t b, int shift,
                                   output letter_t x, output letter_t y);
    int r1, c1, r2, c2;
    find_cell(a, r1, c1);
    find_cell(b, r2, c2);
    if (r1 == r2) begin
      x = square_cell(r1, (c1 + shift) % SQUARE_SIDE);
      y = square_cell(r2, (c2 + shift) % SQUARE_SIDE);
    end else if (c1 == c2) begin
      x = square_cell((r1 + shift) % SQUARE_SIDE, c1);
      y = square_cell((r2 + shift) % SQUARE_SIDE, c2);
    end else begin
      x = square_cell(r1, c2);
      y = square_cell(r2, c1);
    end
  endfunction

  function automatic void push_word(letter_t l, logic lv, logic err);
    cipher_word_t w;
    w.letter = l;
    w.lv     = lv;
    w.eom    = 1'b0;
    w.err    = err;
    due_words.insert(due_words.size(), w);
  endfunction

  function automatic void push_enc_pair(letter_t a, letter_t b);
    letter_t x, y;
    map_pair(a, b, 1, x, y);
    push_word(x, 1'b1, 1'b0);
    push_word(y, 1'b1, 1'b0);
  endfunction

  // Work out the result words one accepted letter causes
  function automatic void advance_cipher(letter_t raw, logic fin);
    letter_t l, fill, x, y;
    int base;
    l    = as_i(raw);
    fill = as_i(filler);
    base = due_words.size();
    if (!decipher) begin
      if (!held_valid) begin
        if (fin) begin
          push_enc_pair(l, fill);
        end else begin
          held_letter = l;
          held_valid  = 1'b1;
        end
      end else if (held_letter == l) begin
        // doubled letter: pad the first, keep the second waiting
        push_enc_pair(held_letter, fill);
        if (fin) push_enc_pair(l, fill);
      end else begin
        push_enc_pair(held_letter, l);
        held_valid  = 1'b0;
        held_letter = '0;
      end
    end else begin
      if (!held_valid) begin
        if (fin) begin
          push_word('0, 1'b0, 1'b1);
        end else begin
          held_letter = l;
          held_valid  = 1'b1;
        end
      end else begin
        // drop plain letters equal to the filler
        map_pair(held_letter, l, SQUARE_SIDE - 1, x, y);
        if (x != fill) push_word(x, 1'b1, 1'b0);
        if (y != fill) push_word(y, 1'b1, 1'b0);
        if (fin && due_words.size() == base) push_word('0, 1'b0, 1'b0);
        held_valid  = 1'b0;
        held_letter = '0;
      end
    end
    if (fin) begin
      held_valid  = 1'b0;
      held_letter = '0;
      if (due_words.size() > base) due_words[due_words.size() - 1].eom = 1'b1;
    end
  endfunction

  initial begin
    fail_count = 0;
    words_due  = 0;
  end

  // Compare leaving words, predict from arriving letters, track the registers
  always @(posedge clk) begin
    cipher_word_t w;
    if (!rst_n) begin
      decipher    = 1'b0;
      square      = '0;
      filler      = FILLER_RESET;
      held_letter = '0;
      held_valid  = 1'b0;
      due_words.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_words.size() == 0) begin
          $display("%0t: unexpected word, got letter %0d lv %0b eom %0b err %0b", $time,
                   out_ch.out_letter, out_ch.letter_valid, out_ch.end_of_message,
                   out_ch.odd_error);
          fail_count++;
        end else begin
          w = due_words.pop_front();
          if (out_ch.out_letter !== w.letter || out_ch.letter_valid !== w.lv ||
              out_ch.end_of_message !== w.eom || out_ch.odd_error !== w.err) begin
            $display("%0t: expected letter %0d lv %0b eom %0b err %0b, got letter %0d lv %0b eom %0b err %0b",
                     $time, w.letter, w.lv, w.eom, w.err, out_ch.out_letter,
                     out_ch.letter_valid, out_ch.end_of_message, out_ch.odd_error);
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) advance_cipher(in_ch.letter, in_ch.final_letter);
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MODE:   decipher = cfg_data[0];
          REG_FILLER: filler = cfg_data[LW-1:0];
          REG_ROW0, REG_ROW1, REG_ROW2, REG_ROW3, REG_ROW4:
            square[int'(cfg_index) - int'(REG_ROW0)] = cfg_data[ROW_W-1:0];
          default: ;
        endcase
      end
    end
    words_due = due_words.size();
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfc_pkg::*;

  typedef enum {SQ_PERM, SQ_RAW, SQ_ONES, SQ_ZERO} square_kind_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  int                    fail_count;
  int                    words_due;

  pfc_in_if  in_ch ();
  pfc_out_if out_ch ();

  // Stimulus state
  bit      idle_on  = 1'b1;
  bit      hold_req = 1'b0;
  int      in_odds  = 0;
  int      sent     = 0;
  letter_t sq [NUM_ROWS][NUM_COLS];
  bit      sq_is_perm;
  int      fill_row, fill_col;
  bit      cfg_mode_shadow = 1'b0;

  always #6 clk = ~clk;

  playfair_digraph_cipher_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pfc_word_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .words_due  (words_due)
  );

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
  endtask

  // Build a square of the given kind and write every register
  task automatic configure(square_kind_t kind, letter_t missing, letter_t fill, bit mode);
    letter_t                pool [25];
    letter_t                t;
    logic [ROW_W-1:0]       row_word;
    int                     n, m;
    n = 0;
    for (int v = 0; v < 26; v++) begin
      if (letter_t'(v) != missing) begin
        pool[n] = letter_t'(v);
        n++;
      end
    end
    for (int k = 24; k > 0; k--) begin
      m       = $urandom_range(0, k);
      t       = pool[k];
      pool[k] = pool[m];
      pool[m] = t;
    end
    sq_is_perm = (kind == SQ_PERM) && (missing == LETTER_J);
    fill_row   = 0;
    fill_col   = 0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        case (kind)
          SQ_PERM: sq[r][c] = pool[r*NUM_COLS + c];
          SQ_RAW:  sq[r][c] = letter_t'($urandom_range(0, 31));
          SQ_ONES: sq[r][c] = '1;
          default: sq[r][c] = '0;
        endcase
        row_word[c*LW +: LW] = sq[r][c];
        if (sq[r][c] == ((fill == LETTER_J) ? LETTER_I : fill)) begin
          fill_row = r;
          fill_col = c;
        end
      end
      put_reg(cfg_reg_t'(int'(REG_ROW0) + r), CFG_DATA_W'(row_word));
    end
    put_reg(REG_FILLER, CFG_DATA_W'(fill));
    put_reg(REG_MODE, CFG_DATA_W'(mode));
    cfg_we <= 1'b0;
  endtask

  // Offer one word, with an occasional burst of idling first
  task automatic send_word(letter_t l, bit fin);
    if (idle_on && in_odds != 0 && $urandom_range(0, in_odds * 2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.letter       <= l;
    in_ch.final_letter <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  // Stop offering and wait for every predicted word to leave
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (words_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic send_plain(int len, bit finish);
    letter_t l, prev;
    prev = '0;
    for (int k = 0; k < len; k++) begin
      l = (k > 0 && $urandom_range(0, 3) == 0) ? prev : letter_t'($urandom_range(0, 25));
      send_word(l, finish && k == len - 1);
      prev = l;
    end
  endtask

  // Cipher pairs, some shaped so that a half or both halves decode to the filler
  task automatic send_cipher(int pairs, bit lone);
    letter_t a, b;
    int      pick, c1, r2;
    for (int k = 0; k < pairs; k++) begin
      a = letter_t'($urandom_range(0, 25));
      b = letter_t'($urandom_range(0, 25));
      if (sq_is_perm && $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 2);
        c1   = (fill_col + $urandom_range(1, NUM_COLS - 1)) % NUM_COLS;
        r2   = (fill_row + $urandom_range(1, NUM_ROWS - 1)) % NUM_ROWS;
        if (pick == 0) begin
          a = sq[fill_row][c1];
          b = sq[r2][fill_col];
        end else if (pick == 1) begin
          a = sq[r2][fill_col];
          b = sq[fill_row][c1];
        end else begin
          a = sq[fill_row][(fill_col + 1) % NUM_COLS];
          b = a;
        end
      end
      send_word(a, 1'b0);
      send_word(b, !lone && k == pairs - 1);
    end
    if (lone) send_word(letter_t'($urandom_range(0, 25)), 1'b1);
  endtask

  // Receiver: stall bursts, calm stretches and one long hold-off
  initial begin
    int hold, span, odds;
    out_ch.ready = 1'b0;
    hold = 0;
    span = 0;
    odds = 0;
    forever begin
      @(negedge clk);
      if (span == 0) begin
        span = $urandom_range(20, 80);
        odds = $urandom_range(0, 3);
      end
      span--;
      if (hold_req) begin
        hold_req = 1'b0;
        hold     = 120;
      end
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && odds != 0 && $urandom_range(0, odds * 3) == 0) begin
        hold = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Main sequence
  initial begin
    square_kind_t kind;
    letter_t      fill, missing;
    int           phase_no, pick;
    in_ch.valid        = 1'b0;
    in_ch.letter       = '0;
    in_ch.final_letter = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset square of zeros, letter extremes
    send_word(letter_t'(0), 1'b0);
    send_word(letter_t'(25), 1'b1);
    drain();

    configure(SQ_PERM, LETTER_J, FILLER_RESET, 1'b0);
    // same row with wrap, same column with wrap, rectangle
    send_word(sq[0][0], 1'b0);
    send_word(sq[0][4], 1'b0);
    send_word(sq[0][2], 1'b0);
    send_word(sq[4][2], 1'b0);
    send_word(sq[1][1], 1'b0);
    send_word(sq[3][3], 1'b0);
    // doubled letter inside a message
    send_word(letter_t'(11), 1'b0);
    send_word(letter_t'(11), 1'b0);
    send_word(letter_t'(14), 1'b0);
    // j read as i, then a doubled final letter
    send_word(LETTER_J, 1'b0);
    send_word(LETTER_I, 1'b0);
    send_word(LETTER_I, 1'b1);
    // lone final letter
    send_word(letter_t'(25), 1'b1);
    // doubled filler
    send_word(FILLER_RESET, 1'b0);
    send_word(FILLER_RESET, 1'b0);
    send_word(letter_t'(1), 1'b1);
    // switch to decrypt with a letter waiting
    send_word(letter_t'(2), 1'b0);
    drain();
    put_reg(REG_MODE, CFG_DATA_W'(1));
    cfg_we <= 1'b0;
    send_word(letter_t'(3), 1'b1);
    // lone cipher letter, then a pair decoding to two fillers
    send_word(letter_t'(4), 1'b1);
    send_word(sq[fill_row][(fill_col + 1) % NUM_COLS], 1'b0);
    send_word(sq[fill_row][(fill_col + 1) % NUM_COLS], 1'b1);
    drain();

    // Random phases, each with its own settings
    phase_no = 0;
    while (sent < 265) begin
      phase_no++;
      idle_on = (sent < 215);
      in_odds = $urandom_range(0, 3);
      pick    = $urandom_range(0, 9);
      kind    = (pick <= 6) ? SQ_PERM : (pick == 7) ? SQ_RAW : (pick == 8) ? SQ_ONES : SQ_ZERO;
      missing = (pick == 6) ? LETTER_I : LETTER_J;
      pick    = $urandom_range(0, 7);
      fill    = (pick == 0) ? letter_t'(0) : (pick == 1) ? letter_t'(25) :
                (pick == 2) ? LETTER_J : (pick == 3) ? FILLER_RESET :
                letter_t'($urandom_range(0, 25));
      configure(kind, missing, fill, 1'($urandom_range(0, 1)));
      // long receiver hold-off while letters keep coming
      if (phase_no == 3) begin
        hold_req = 1'b1;
        send_plain(30, 1'b1);
      end
      repeat ($urandom_range(2, 5)) begin
        if (i_checker_mode_decrypt()) send_cipher($urandom_range(1, 6), $urandom_range(0, 4) == 0);
        else send_plain($urandom_range(1, 10), 1'b1);
      end
      // leave a message open across the next settings now and then
      if ($urandom_range(0, 3) == 0) send_plain($urandom_range(1, 3), 1'b0);
      drain();
    end

    repeat (10) @(negedge clk);
    if (fail_count == 0 && words_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Mode as last written by this bench
  function automatic bit i_checker_mode_decrypt();
    return cfg_mode_shadow;
  endfunction

  always @(posedge clk) begin
    if (cfg_we && cfg_reg_t'(cfg_index) == REG_MODE) cfg_mode_shadow <= cfg_data[0];
  end

  initial begin
    #3ms;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pfc_pkg.sv
rtl/pfc_in_if.sv
rtl/pfc_out_if.sv
rtl/pfc_queue.sv
rtl/pfc_front.sv
rtl/pfc_back.sv
rtl/playfair_digraph_cipher_top.sv
tb/pfc_word_checker.sv
tb/tb.sv
